// ===== rtl/sws_pkg.sv =====
// Shared types, codes and the checksum fold for the stop-and-wait sender.
package sws_pkg;

  localparam int unsigned HEADER_BYTES = 10;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_CONNECT    = 3'd1;
  localparam logic [2:0] CMD_SEND       = 3'd2;
  localparam logic [2:0] CMD_DISCONNECT = 3'd3;
  localparam logic [2:0] CMD_HEADER     = 3'd4;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_SYN  = 3'd1;
  localparam logic [2:0] ACT_ACK  = 3'd2;
  localparam logic [2:0] ACT_FIN  = 3'd3;
  localparam logic [2:0] ACT_DATA = 3'd4;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_CONNECTED = 3'd1;
  localparam logic [2:0] ST_DELIVERED = 3'd2;
  localparam logic [2:0] ST_CLOSED    = 3'd3;
  localparam logic [2:0] ST_FAILED    = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  localparam logic [2:0] REG_LOCAL_PORT   = 3'd0;
  localparam logic [2:0] REG_REMOTE_PORT  = 3'd1;
  localparam logic [2:0] REG_SYN_CODE     = 3'd2;
  localparam logic [2:0] REG_ACK_CODE     = 3'd3;
  localparam logic [2:0] REG_FIN_CODE     = 3'd4;
  localparam logic [2:0] REG_SYNACK_CODE  = 3'd5;
  localparam logic [2:0] REG_REPLY_WAIT   = 3'd6;
  localparam logic [2:0] REG_LINGER       = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYN    = 3'd1,
    PH_LINGER = 3'd2,
    PH_CONN   = 3'd3,
    PH_DATA   = 3'd4,
    PH_FIN    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [7:0]  syn_code;
    logic [7:0]  ack_code;
    logic [7:0]  fin_code;
    logic [7:0]  synack_code;
    logic [15:0] reply_wait_ticks;
    logic [15:0] linger_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       hdr_ok;
    logic [7:0] seq;
    logic [7:0] flag;
  } q_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] hdr_src;
    logic [15:0] hdr_dst;
    logic [15:0] length;
    logic [15:0] checksum;
    logic [7:0]  seq;
    logic [7:0]  flag;
    logic [2:0]  status;
  } res_t;

  // Folds a sum of up to eight 16-bit words into a ones'-complement sum.
  function automatic logic [15:0] oc_fold(input logic [18:0] total);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return s2[15:0];
  endfunction

endpackage

// ===== rtl/stop_and_wait_sender.sv =====
// Top level of the stop-and-wait link sender with its configuration registers.
// Each accepted event gives exactly one result transaction, and a new event can be
// taken every cycle while the queue is not full: the front checks the received
// header checksum and queues the event in a two-entry queue, and the protocol
// engine updates phase, timer and sequence number and writes one result into the
// output register per cycle while the output register is empty or being accepted.
// The engine's state update sets the rate of one transaction per cycle under that
// condition; a result passes the queue, then the output register. Configuration
// writes are always accepted and should be made while no event is in flight.
module stop_and_wait_sender import sws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // cmd
  input  logic [79:0] in_tdata,   // rx source port, rx destination port, rx_length,
                                  // rx_checksum, rx_seq, rx_flag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [5:0]  out_tuser,  // action, status
  output logic [79:0] out_tdata,  // out source port, out destination port, out_length,
                                  // out_checksum, out_seq, out_flag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  logic    q_full;
  logic    q_push;
  q_item_t push_item;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_item;
  res_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_port       <= 16'd0;
      cfg_r.remote_port      <= 16'd0;
      cfg_r.syn_code         <= 8'd1;
      cfg_r.ack_code         <= 8'd2;
      cfg_r.fin_code         <= 8'd4;
      cfg_r.synack_code      <= 8'd3;
      cfg_r.reply_wait_ticks <= 16'd500;
      cfg_r.linger_ticks     <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOCAL_PORT:  cfg_r.local_port       <= cfg_data;
        REG_REMOTE_PORT: cfg_r.remote_port      <= cfg_data;
        REG_SYN_CODE:    cfg_r.syn_code         <= cfg_data[7:0];
        REG_ACK_CODE:    cfg_r.ack_code         <= cfg_data[7:0];
        REG_FIN_CODE:    cfg_r.fin_code         <= cfg_data[7:0];
        REG_SYNACK_CODE: cfg_r.synack_code      <= cfg_data[7:0];
        REG_REPLY_WAIT:  cfg_r.reply_wait_ticks <= cfg_data;
        REG_LINGER:      cfg_r.linger_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  sws_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  sws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  sws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = {res.status, res.action};
  assign out_tdata = {res.flag, res.seq, res.checksum, res.length,
                      res.hdr_dst, res.hdr_src};

  a_none_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == ACT_NONE) |-> (out_tdata == '0))
    else $error("result without action carries header fields");

  a_status_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[5:3] != ST_NONE) |-> (out_tuser[2:0] == ACT_NONE))
    else $error("status reported together with a send");

  a_data_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == ACT_DATA) |-> (out_tdata[63:32] == '0))
    else $error("data segment with nonzero length or checksum");

  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> q_full)
    else $error("queue lost an entry while stalled");

endmodule

// ===== rtl/sws_front.sv =====
// Input side: accepts events, checks the received header checksum, fills the queue.
module sws_front import sws_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // cmd
  input  logic [79:0] in_tdata,   // rx source port, rx destination port, rx_length,
                                  // rx_checksum, rx_seq, rx_flag
  input  logic        q_full,
  output logic        q_push,
  output q_item_t     q_item
);

  logic [18:0] total;

  assign total = {3'd0, in_tdata[15:0]} + {3'd0, in_tdata[31:16]}
               + {3'd0, in_tdata[47:32]} + {3'd0, in_tdata[63:48]}
               + {3'd0, in_tdata[79:64]};

  assign in_tready     = !q_full;
  assign q_push        = in_tvalid && !q_full;
  assign q_item.cmd    = in_tuser;
  assign q_item.hdr_ok = (oc_fold(total) == 16'hffff);
  assign q_item.seq    = in_tdata[71:64];
  assign q_item.flag   = in_tdata[79:72];

endmodule

// ===== rtl/sws_queue.sv =====
// Two-entry queue between the classifying front and the protocol engine.
module sws_queue import sws_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t item
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/sws_back.sv =====
// Protocol engine: phase, timer and sequence state, header build and output register.
module sws_back import sws_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic        out_valid_r;
  res_t        out_r;

  logic [2:0]  act;
  logic [2:0]  status;
  logic [2:0]  resend_act;
  logic        waiting;
  logic [7:0]  ctrl_flag;
  logic [18:0] ctrl_total;
  res_t        res;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign waiting = (phase_r == PH_SYN) || (phase_r == PH_LINGER) ||
                   (phase_r == PH_DATA) || (phase_r == PH_FIN);

  always_comb begin
    priority if (phase_r == PH_SYN) begin
      resend_act = ACT_SYN;
    end else if (phase_r == PH_FIN) begin
      resend_act = ACT_FIN;
    end else begin
      resend_act = ACT_DATA;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    seq_nxt   = seq_r;
    act       = ACT_NONE;
    status    = ST_NONE;
    unique case (q_item.cmd)
      CMD_TICK: begin
        if (waiting) begin
          if (timer_r <= 16'd1) begin
            timer_nxt = '0;
            if (phase_r == PH_LINGER) begin
              phase_nxt = PH_CONN;
              status    = ST_CONNECTED;
            end else begin
              act = resend_act;
            end
          end else begin
            timer_nxt = timer_r - 16'd1;
          end
        end
      end
      CMD_CONNECT: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_SYN;
          act       = ACT_SYN;
        end else begin
          status = ST_IGNORED;
        end
      end
      CMD_SEND: begin
        if (phase_r == PH_CONN) begin
          phase_nxt = PH_DATA;
          act       = ACT_DATA;
        end else begin
          status = ST_IGNORED;
        end
      end
      CMD_DISCONNECT: begin
        if (phase_r == PH_CONN) begin
          phase_nxt = PH_FIN;
          act       = ACT_FIN;
        end else begin
          status = ST_IGNORED;
        end
      end
      CMD_HEADER: begin
        priority if (!waiting) begin
          status = ST_IGNORED;
        end else if (phase_r == PH_LINGER) begin
          act = ACT_ACK;
        end else if (!q_item.hdr_ok) begin
          act = resend_act;
        end else if (phase_r == PH_SYN) begin
          if (q_item.flag != cfg.synack_code) begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            status    = ST_FAILED;
          end else begin
            phase_nxt = PH_LINGER;
            act       = ACT_ACK;
          end
        end else if (phase_r == PH_DATA) begin
          if (q_item.flag != cfg.ack_code) begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            status    = ST_FAILED;
          end else if (q_item.seq != seq_r) begin
            act = ACT_DATA;
          end else begin
            seq_nxt   = seq_r + 8'd1;
            phase_nxt = PH_CONN;
            timer_nxt = '0;
            status    = ST_DELIVERED;
          end
        end else begin
          status    = (q_item.flag != cfg.fin_code) ? ST_FAILED : ST_CLOSED;
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
    if (act != ACT_NONE) begin
      timer_nxt = (act == ACT_ACK) ? cfg.linger_ticks : cfg.reply_wait_ticks;
    end
  end

  always_comb begin
    unique case (act)
      ACT_SYN: ctrl_flag = cfg.syn_code;
      ACT_FIN: ctrl_flag = cfg.fin_code;
      default: ctrl_flag = cfg.ack_code;
    endcase
  end

  assign ctrl_total = {3'd0, cfg.local_port} + {3'd0, cfg.remote_port}
                    + 19'(HEADER_BYTES) + {3'd0, ctrl_flag, 8'd0};

  always_comb begin
    res        = '0;
    res.action = act;
    res.status = status;
    if (act == ACT_DATA) begin
      res.hdr_src = cfg.local_port;
      res.hdr_dst = cfg.remote_port;
      res.seq     = seq_r;
      res.flag    = cfg.ack_code;
    end else if (act != ACT_NONE) begin
      res.hdr_src  = cfg.local_port;
      res.hdr_dst  = cfg.remote_port;
      res.length   = 16'(HEADER_BYTES);
      res.checksum = ~oc_fold(ctrl_total);
      res.flag     = ctrl_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        timer_r <= timer_nxt;
        seq_r   <= seq_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
